FILE: rtl/nearest_target_window_hold_defines.svh
// Assertion macros shared by the nearest target window hold RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef NEAREST_TARGET_WINDOW_HOLD_DEFINES_SVH
`define NEAREST_TARGET_WINDOW_HOLD_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define NTWH_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define NTWH_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define NTWH_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ntwh_pkg.sv
// Shared types and constants for the nearest target window hold block.
// Used by ntwh_ctrl, ntwh_datapath and the top level; depends on nothing.
package ntwh_pkg;

   localparam int WINDOW_MAX = 16;
   localparam int SLOT_W     = $clog2(WINDOW_MAX);
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_LIMIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE    = 2'd2;

   localparam logic [15:0] DIST_THRESHOLD_RESET = 16'd640;
   localparam logic [7:0]  EMPTY_LIMIT_RESET    = 8'd9;
   localparam logic [4:0]  WINDOW_SIZE_RESET    = 5'd10;

   localparam logic KIND_TARGET    = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // Highest even bit of the 32-bit radicand, where the root search starts.
   localparam logic [31:0] ROOT_START = 32'h4000_0000;

   typedef struct packed {
      logic [15:0]        radius;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_ROOT,
      ST_BEST,
      ST_PUSH,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul_x;
      logic mul_y;
      logic root_step;
      logic best_update;
      logic push;
      logic scan_start;
      logic scan_issue;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic root_last;
      logic out_due;
      logic keep_zero;
      logic scan_last;
      logic out_busy;
   } status_type;

endpackage

FILE: rtl/nearest_target_window_hold.sv
// Top level of the nearest target window hold block.
// Depends on ntwh_pkg, ntwh_ctrl and ntwh_datapath.

// Target positions arrive as transactions of kind target, and a transaction of kind
// frame end closes each frame. One item is worked on at a time. A target is
// accepted, squared as x*x and then y*y on the single shared 16x16 multiplier,
// passed through the bit-pair square root unit and then compared against the
// threshold and the frame's best. A frame end pushes the frame's best into the
// history; it then ends when output has not started yet, goes straight to its
// result when keep is zero, and otherwise scans the window first, where
// keep is the effective window size minus one; the window scan reads the history
// memory one entry per cycle through its single read port, newest first. The
// history needs no clearing pass: a valid bit per entry makes never written
// entries read as empty right after reset. A finished result sits in an output
// register until it is taken, and the block accepts new transactions meanwhile;
// only a second result stalls, in its final cycle, until the first one has left.
// Configuration writes land at once and are meant for times when the block is idle.
module nearest_target_window_hold (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ntwh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ntwh_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic signed [15:0]              req_target_x,
   input  logic signed [15:0]              req_target_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [15:0]              rsp_out_x,
   output logic signed [15:0]              rsp_out_y,
   output logic [15:0]                     rsp_out_dist,
   output logic                            rsp_out_found
);

   // The controller and the datapath talk only through these two structs.
   ntwh_pkg::cmd_type    cmd;
   ntwh_pkg::status_type status;

   ntwh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ntwh_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_target_x  (req_target_x),
      .req_target_y  (req_target_y),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_dist  (rsp_out_dist),
      .rsp_out_found (rsp_out_found),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

FILE: rtl/ntwh_ctrl.sv
// Sequencing state machine for the nearest target window hold block.
// Depends on ntwh_pkg; drives the datapath through command and status structs.
module ntwh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_ready,
   input  ntwh_pkg::status_type status,
   output ntwh_pkg::cmd_type    cmd
);

   ntwh_pkg::state_type state_ff;
   ntwh_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntwh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ntwh_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == ntwh_pkg::KIND_TARGET) begin
                  state_in = ntwh_pkg::ST_MUL_X;
               end else begin
                  state_in = ntwh_pkg::ST_PUSH;
               end
            end
         end
         ntwh_pkg::ST_MUL_X: state_in = ntwh_pkg::ST_MUL_Y;
         ntwh_pkg::ST_MUL_Y: state_in = ntwh_pkg::ST_ROOT;
         ntwh_pkg::ST_ROOT: begin
            if (status.root_last) begin
               state_in = ntwh_pkg::ST_BEST;
            end
         end
         ntwh_pkg::ST_BEST:  state_in = ntwh_pkg::ST_IDLE;
         ntwh_pkg::ST_PUSH:  state_in = ntwh_pkg::ST_CHECK;
         ntwh_pkg::ST_CHECK: begin
            if (!status.out_due) begin
               state_in = ntwh_pkg::ST_IDLE;
            end else if (status.keep_zero) begin
               state_in = ntwh_pkg::ST_FINISH;
            end else begin
               state_in = ntwh_pkg::ST_SCAN;
            end
         end
         ntwh_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ntwh_pkg::ST_DRAIN;
            end
         end
         ntwh_pkg::ST_DRAIN: state_in = ntwh_pkg::ST_FINISH;
         ntwh_pkg::ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = ntwh_pkg::ST_IDLE;
            end
         end
         default: state_in = ntwh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ntwh_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ntwh_pkg::ST_MUL_X:  cmd.mul_x       = 1'b1;
         ntwh_pkg::ST_MUL_Y:  cmd.mul_y       = 1'b1;
         ntwh_pkg::ST_ROOT:   cmd.root_step   = 1'b1;
         ntwh_pkg::ST_BEST:   cmd.best_update = 1'b1;
         ntwh_pkg::ST_PUSH:   cmd.push        = 1'b1;
         ntwh_pkg::ST_CHECK:  cmd.scan_start  = 1'b1;
         ntwh_pkg::ST_SCAN:   cmd.scan_issue  = 1'b1;
         ntwh_pkg::ST_DRAIN:  cmd             = '0;
         ntwh_pkg::ST_FINISH: cmd.publish     = !status.out_busy;
         default:             cmd             = '0;
      endcase
   end

endmodule

FILE: rtl/ntwh_datapath.sv
// Datapath of the nearest target window hold block: registers, multiplier,
// root unit, history memory and window scan. Depends on ntwh_pkg and the defines header.
`include "nearest_target_window_hold_defines.svh"

module ntwh_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ntwh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ntwh_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic signed [15:0]              req_target_x,
   input  logic signed [15:0]              req_target_y,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic signed [15:0]              rsp_out_x,
   output logic signed [15:0]              rsp_out_y,
   output logic [15:0]                     rsp_out_dist,
   output logic                            rsp_out_found,
   input  ntwh_pkg::cmd_type               cmd,
   output ntwh_pkg::status_type            status
);

   localparam int SLOT_W = ntwh_pkg::SLOT_W;
   localparam int CNT_W  = ntwh_pkg::CNT_W;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ntwh_pkg::WINDOW_MAX - 1);
   localparam logic [CNT_W-1:0]  FRAMES_MAX = CNT_W'(ntwh_pkg::WINDOW_MAX);

   // Configuration registers.
   logic [15:0] dist_threshold_ff;
   logic [7:0]  empty_limit_ff;
   logic [4:0]  window_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_threshold_ff <= ntwh_pkg::DIST_THRESHOLD_RESET;
         empty_limit_ff    <= ntwh_pkg::EMPTY_LIMIT_RESET;
         window_size_ff    <= ntwh_pkg::WINDOW_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ntwh_pkg::CSR_DIST_THRESHOLD: dist_threshold_ff <= csr_wdata;
            ntwh_pkg::CSR_EMPTY_LIMIT:    empty_limit_ff    <= csr_wdata[7:0];
            ntwh_pkg::CSR_WINDOW_SIZE:    window_size_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Effective window size and the number of history entries it covers.
   logic [CNT_W-1:0] ws_eff;
   logic [CNT_W-1:0] keep;

   always_comb begin
      if (32'(window_size_ff) > 32'(ntwh_pkg::WINDOW_MAX)) begin
         ws_eff = FRAMES_MAX;
      end else begin
         ws_eff = CNT_W'(window_size_ff);
      end
      keep = (ws_eff == '0) ? '0 : ws_eff - CNT_W'(1);
   end

   // Target capture, squaring through one shared multiplier, and root unit.
   logic signed [15:0] x_ff;
   logic signed [15:0] y_ff;
   logic [15:0]        ax;
   logic [15:0]        ay;
   logic [15:0]        mul_op;
   logic [31:0]        product;
   logic [31:0]        sq_ff;
   logic [31:0]        v_ff;
   logic [31:0]        v_in;
   logic [31:0]        res_ff;
   logic [31:0]        res_in;
   logic [31:0]        bit_ff;
   logic [32:0]        trial;

   assign ax      = x_ff[15] ? (~x_ff + 16'd1) : x_ff;
   assign ay      = y_ff[15] ? (~y_ff + 16'd1) : y_ff;
   assign mul_op  = cmd.mul_y ? ay : ax;
   assign product = mul_op * mul_op;
   assign trial   = {1'b0, res_ff} + {1'b0, bit_ff};

   always_comb begin
      if ({1'b0, v_ff} >= trial) begin
         v_in   = v_ff - trial[31:0];
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         v_in   = v_ff;
         res_in = res_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff <= req_target_x;
         y_ff <= req_target_y;
      end
      if (cmd.mul_x) begin
         sq_ff <= product;
      end
      if (cmd.mul_y) begin
         v_ff   <= sq_ff + product;
         res_ff <= '0;
      end else if (cmd.root_step) begin
         v_ff   <= v_in;
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (cmd.mul_y) begin
         bit_ff <= ntwh_pkg::ROOT_START;
      end else if (cmd.root_step) begin
         bit_ff <= bit_ff >> 2;
      end
   end

   assign status.root_last = (bit_ff == 32'd1);

   // Nearest accepted target of the current frame.
   ntwh_pkg::entry_type best_ff;
   logic                best_valid_ff;
   logic [15:0]         radius_now;
   logic                take;

   assign radius_now = res_ff[15:0];
   assign take = (radius_now <= dist_threshold_ff) &&
                 (!best_valid_ff || (radius_now < best_ff.radius));

   always_ff @(posedge clock) begin
      if (cmd.best_update && take) begin
         best_ff.x      <= x_ff;
         best_ff.y      <= y_ff;
         best_ff.radius <= radius_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         best_valid_ff <= 1'b0;
      end else if (cmd.best_update && take) begin
         best_valid_ff <= 1'b1;
      end
   end

   // History memory; entries never written since reset read as empty.
   ntwh_pkg::entry_type                history_mem [ntwh_pkg::WINDOW_MAX];
   logic [ntwh_pkg::WINDOW_MAX-1:0]    hist_valid_ff;
   logic [SLOT_W-1:0]                  write_slot_ff;
   logic [CNT_W-1:0]                   frames_seen_ff;
   logic [SLOT_W-1:0]                  rd_ptr_ff;
   ntwh_pkg::entry_type                rd_entry_ff;
   logic                               rd_ok_ff;
   ntwh_pkg::entry_type                push_entry;

   assign push_entry = best_valid_ff ? best_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         history_mem[write_slot_ff] <= push_entry;
      end
      if (cmd.scan_issue) begin
         rd_entry_ff <= history_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff  <= '0;
         write_slot_ff  <= '0;
         frames_seen_ff <= '0;
         rd_ok_ff       <= 1'b0;
      end else begin
         if (cmd.push) begin
            hist_valid_ff[write_slot_ff] <= 1'b1;
            write_slot_ff <= (write_slot_ff == SLOT_LAST) ? '0 : write_slot_ff + SLOT_W'(1);
            if (frames_seen_ff < FRAMES_MAX) begin
               frames_seen_ff <= frames_seen_ff + CNT_W'(1);
            end
         end
         if (cmd.scan_issue) begin
            rd_ok_ff <= hist_valid_ff[rd_ptr_ff];
         end
      end
   end

   // Window scan from the newest entry backward, one read each cycle.
   logic [SLOT_W-1:0]  scan_cnt_ff;
   logic               rd_live_ff;
   logic [SLOT_W-1:0]  empties_ff;
   logic               pick_found_ff;
   ntwh_pkg::entry_type pick_ff;
   logic [15:0]        rd_radius;

   assign rd_radius = rd_ok_ff ? rd_entry_ff.radius : 16'd0;

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         rd_ptr_ff <= (write_slot_ff == '0) ? SLOT_LAST : write_slot_ff - SLOT_W'(1);
      end else if (cmd.scan_issue) begin
         rd_ptr_ff <= (rd_ptr_ff == '0) ? SLOT_LAST : rd_ptr_ff - SLOT_W'(1);
      end
      if (rd_live_ff && (rd_radius != 16'd0) && !pick_found_ff) begin
         pick_ff <= rd_entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff   <= '0;
         rd_live_ff    <= 1'b0;
         empties_ff    <= '0;
         pick_found_ff <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan_issue;
         if (cmd.scan_start) begin
            scan_cnt_ff   <= '0;
            empties_ff    <= '0;
            pick_found_ff <= 1'b0;
         end else begin
            if (cmd.scan_issue) begin
               scan_cnt_ff <= scan_cnt_ff + SLOT_W'(1);
            end
            if (rd_live_ff) begin
               if (rd_radius == 16'd0) begin
                  empties_ff <= empties_ff + SLOT_W'(1);
               end else begin
                  pick_found_ff <= 1'b1;
               end
            end
         end
      end
   end

   assign status.out_due   = (frames_seen_ff >= ws_eff);
   assign status.keep_zero = (keep == '0);
   assign status.scan_last = ((CNT_W'(scan_cnt_ff) + CNT_W'(1)) == keep);

   // Result register; it holds a finished result while the next item runs.
   logic rsp_valid_ff;
   logic publish_ok;

   assign publish_ok      = pick_found_ff && (32'(empties_ff) <= 32'(empty_limit_ff));
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_out_x     <= publish_ok ? pick_ff.x : 16'sd0;
         rsp_out_y     <= publish_ok ? pick_ff.y : 16'sd0;
         rsp_out_dist  <= publish_ok ? pick_ff.radius : 16'd0;
         rsp_out_found <= publish_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `NTWH_ALWAYS(a_frames_bounded, frames_seen_ff <= FRAMES_MAX, "frame count overflow")
   `NTWH_ALWAYS(a_root_bit_onehot, $onehot0(bit_ff), "root search bit is not one-hot")
   `NTWH_IMPLY(a_found_radius, rsp_valid_ff && rsp_out_found, rsp_out_dist != '0, "no radius")
   `NTWH_NEXT(a_slot_advances, cmd.push, write_slot_ff != $past(write_slot_ff), "slot stuck")
   `NTWH_IMPLY(a_publish_not_stalled, cmd.publish, !status.out_busy, "result overwritten")

endmodule
